/* rtl/core/ets_pkg.sv */
// ----------------------------------------------------------------------------
// ets_pkg: shared types for the elite and tournament selector
// Commands, the sequencer state, one elite list entry and the control word
// that steers every cell of the elite chain.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

	localparam int unsigned SCORE_W = 32;
	localparam int unsigned SLOT_W  = 8;
	localparam logic [SCORE_W-1:0] SCORE_SENTINEL = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_DRAW  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAW,
		ST_READ
	} state_t;

	typedef enum logic {
		KIND_WINNER = 1'b0,
		KIND_ELITE  = 1'b1
	} kind_t;

	typedef struct packed {
		logic               filled;
		logic [SCORE_W-1:0] score;
		logic [SLOT_W-1:0]  slot;
	} entry_t;

	typedef struct packed {
		logic clear;
		logic insert;
		logic rotate;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/elite_and_tournament_selector_core.sv */
// ----------------------------------------------------------------------------
// elite_and_tournament_selector_core: elite list and tournament selection
// Stores fitness scores, keeps the best ELITE_COUNT of them sorted, and
// picks tournament winners by lowest score.
// ----------------------------------------------------------------------------
// Usage: items enter on the s_axis channel with the command in tuser; clear
// and load give no result, a draw gives one result when tlast marks it final,
// and a read gives ELITE_COUNT results, best first, with tlast on the final
// one. Results leave on m_axis through one output register.
// Sequence: a clear or a load is done as it is accepted. A draw passes
// through the registered read of the score memory and then the draw state. A
// read stays in the read state while the list rotates past the head of the
// elite chain, one entry per cell. A winner or an elite entry is loaded from
// the draw or read state into the output register, which offers it on m_axis.
// The next item is accepted once the current one has finished, even while a
// result still waits in the output register.
// Reset clears the elite list, the running tournament state and the output
// valid flag; the score memory holds no defined contents until written.
// When the receiver stalls, a pending draw result or elite entry waits in its
// state and tready stays low until the output register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module elite_and_tournament_selector_core #(
	parameter int unsigned POP_SIZE    = 256,
	parameter int unsigned ELITE_COUNT = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] score, [39:32] slot
	input  wire logic [39:0] s_axis_tdata,
	// [1:0] command
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] chosen, [39:8] chosen_score, [40] entry_valid, [47:41] zero
	output logic [47:0]      m_axis_tdata,
	// [0] kind
	output logic [0:0]       m_axis_tuser,
	output logic             m_axis_tlast
);

	localparam int unsigned IDX_W = $clog2(POP_SIZE);
	localparam int unsigned CNT_W = (ELITE_COUNT > 1) ? $clog2(ELITE_COUNT) : 1;
	localparam int unsigned SLOT_RANGE = 256;

	// Reduction of the slot field modulo the population size, as a table.
	logic [IDX_W-1:0] slot_mod [SLOT_RANGE];
	for (genvar gi = 0; gi < SLOT_RANGE; gi++) begin : g_mod
		assign slot_mod[gi] = IDX_W'(gi % POP_SIZE);
	end

	ets_pkg::cmd_t                cmd;
	logic [ets_pkg::SCORE_W-1:0]  in_score;
	logic [IDX_W-1:0]             in_idx;
	logic                         accept;

	assign cmd      = ets_pkg::cmd_t'(s_axis_tuser);
	assign in_score = s_axis_tdata[31:0];
	assign in_idx   = slot_mod[s_axis_tdata[39:32]];
	assign accept   = s_axis_tvalid && s_axis_tready;

	ets_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0]            cnt_q, cnt_d;
	logic [IDX_W-1:0]            idx_s1;
	logic                        fin_s1;
	logic [ets_pkg::SCORE_W-1:0] rd_s1;

	logic [ets_pkg::SCORE_W-1:0] run_min_q, run_min_d;
	logic [IDX_W-1:0]            run_win_q, run_win_d;
	logic                        draw_open_q, draw_open_d;

	logic                        out_valid_q;
	ets_pkg::kind_t              out_kind_q;
	logic [ets_pkg::SLOT_W-1:0]  out_chosen_q;
	logic [ets_pkg::SCORE_W-1:0] out_score_q;
	logic                        out_entry_valid_q;
	logic                        out_last_q;

	logic                        out_free;
	logic                        load_win;
	logic                        load_elite;
	logic                        take;
	logic                        drop;

	ets_pkg::cell_ctl_t          ctl;
	ets_pkg::entry_t             new_entry;
	ets_pkg::entry_t             cells [ELITE_COUNT];
	logic                        keeps [ELITE_COUNT];

	assign out_free = !out_valid_q || m_axis_tready;
	assign take     = !draw_open_q || (rd_s1 < run_min_q);

	ets_store #(
		.DEPTH (POP_SIZE),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.we      (accept && (cmd == ets_pkg::CMD_LOAD)),
		.waddr   (in_idx),
		.wdata   (in_score),
		.re      (accept && (cmd == ets_pkg::CMD_DRAW)),
		.raddr   (in_idx),
		.rdata_q (rd_s1)
	);

	assign new_entry.filled = 1'b1;
	assign new_entry.score  = in_score;
	assign new_entry.slot   = ets_pkg::SLOT_W'(in_idx);

	for (genvar gc = 0; gc < ELITE_COUNT; gc++) begin : g_cell
		ets_pkg::entry_t prev_e;
		ets_pkg::entry_t next_e;
		logic            prev_k;

		if (gc == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = cells[gc-1];
			assign prev_k = keeps[gc-1];
		end

		if (gc == ELITE_COUNT - 1) begin : g_tail
			assign next_e = cells[0];
		end else begin : g_mid
			assign next_e = cells[gc+1];
		end

		ets_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_keep  (prev_k),
			.next_entry (next_e),
			.entry_q    (cells[gc]),
			.keep       (keeps[gc])
		);
	end

	// A full list drops a score that is not strictly below its last entry.
	assign drop = cells[ELITE_COUNT-1].filled && (in_score >= cells[ELITE_COUNT-1].score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ets_pkg::ST_IDLE;
			cnt_q       <= '0;
			run_min_q   <= ets_pkg::SCORE_SENTINEL;
			run_win_q   <= '0;
			draw_open_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			run_min_q   <= run_min_d;
			run_win_q   <= run_win_d;
			draw_open_q <= draw_open_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd == ets_pkg::CMD_DRAW)) begin
			idx_s1 <= in_idx;
			fin_s1 <= s_axis_tlast;
		end
	end

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		run_min_d     = run_min_q;
		run_win_d     = run_win_q;
		draw_open_d   = draw_open_q;
		s_axis_tready = 1'b0;
		load_win      = 1'b0;
		load_elite    = 1'b0;
		ctl           = '0;
		case (state_q)
			ets_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (cmd)
						ets_pkg::CMD_CLEAR: ctl.clear = 1'b1;
						ets_pkg::CMD_LOAD:  ctl.insert = !drop;
						ets_pkg::CMD_DRAW:  state_d = ets_pkg::ST_DRAW;
						ets_pkg::CMD_READ: begin
							cnt_d   = '0;
							state_d = ets_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			ets_pkg::ST_DRAW: begin
				// A final draw waits here until the result has somewhere to go.
				if (!fin_s1 || out_free) begin
					if (take) begin
						run_min_d = rd_s1;
						run_win_d = idx_s1;
					end
					draw_open_d = !fin_s1;
					load_win    = fin_s1;
					state_d     = ets_pkg::ST_IDLE;
				end
			end
			ets_pkg::ST_READ: begin
				if (out_free) begin
					load_elite = 1'b1;
					ctl.rotate = 1'b1;
					cnt_d      = cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ELITE_COUNT - 1)) begin
						state_d = ets_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = ets_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_win || load_elite) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_win) begin
			out_kind_q        <= ets_pkg::KIND_WINNER;
			out_chosen_q      <= ets_pkg::SLOT_W'(run_win_d);
			out_score_q       <= run_min_d;
			out_entry_valid_q <= 1'b1;
			out_last_q        <= 1'b1;
		end else if (load_elite) begin
			out_kind_q        <= ets_pkg::KIND_ELITE;
			out_chosen_q      <= cells[0].slot;
			out_score_q       <= cells[0].score;
			out_entry_valid_q <= cells[0].filled;
			out_last_q        <= (cnt_q == CNT_W'(ELITE_COUNT - 1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_entry_valid_q, out_score_q, out_chosen_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/core/ets_store.sv */
// ----------------------------------------------------------------------------
// ets_store: score memory
// One score per individual, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_store #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned AW    = 8
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [ets_pkg::SCORE_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [ets_pkg::SCORE_W-1:0] rdata_q
);

	logic [ets_pkg::SCORE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ets_cell.sv */
// ----------------------------------------------------------------------------
// ets_cell: one entry of the sorted elite chain
// Keeps its entry while it beats the new score, otherwise takes the new entry
// or its upper neighbor's entry. On a read it takes its lower neighbor's entry
// so the list rotates past the head.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ets_pkg::cell_ctl_t          ctl,
	input  wire ets_pkg::entry_t             new_entry,
	input  wire ets_pkg::entry_t             prev_entry,
	input  wire logic                        prev_keep,
	input  wire ets_pkg::entry_t             next_entry,
	output ets_pkg::entry_t                  entry_q,
	output logic                             keep
);

	// Strictly better entries stay, so a new score lands ahead of equal ones.
	assign keep = entry_q.filled && (entry_q.score < new_entry.score);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.filled <= 1'b0;
			entry_q.score  <= ets_pkg::SCORE_SENTINEL;
			entry_q.slot   <= '0;
		end else if (ctl.clear) begin
			entry_q.filled <= 1'b0;
			entry_q.score  <= ets_pkg::SCORE_SENTINEL;
			entry_q.slot   <= '0;
		end else if (ctl.insert) begin
			if (!keep) begin
				entry_q <= prev_keep ? new_entry : prev_entry;
			end
		end else if (ctl.rotate) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire
